>>> rtl/nsps_pkg.sv
// Shared constants and trig tables for the phase-shift wrapped-phase pipeline.
`timescale 1ns / 1ps
package nsps_pkg;

    localparam int MAX_STEPS    = 8;
    localparam int MIN_STEPS    = 3;
    localparam int STEP_BITS    = 4;
    localparam int SAMPLE_BITS  = 12;
    localparam int PHASE_BITS   = 16;
    localparam int MEAN_BITS    = 16;
    localparam int TRIG_BITS    = 16;
    localparam int ROWS         = MAX_STEPS - MIN_STEPS + 1;
    localparam int ROW_BITS     = $clog2(ROWS);
    localparam int PROD_BITS    = SAMPLE_BITS + 1 + TRIG_BITS;
    localparam int SUM_BITS     = PROD_BITS + $clog2(MAX_STEPS);
    localparam int TOT_BITS     = SAMPLE_BITS + $clog2(MAX_STEPS);
    localparam int NUM_BITS     = TOT_BITS + 4;
    localparam int REM_BITS     = $clog2(MAX_STEPS);
    localparam int ANGLE_BITS   = 32;
    localparam int CORDIC_ITERS = 30;
    localparam int NORM_EXP     = 40;
    localparam int CW           = NORM_EXP + 5;
    localparam int SHIFT_BITS   = 6;
    localparam int MAG_BITS     = SUM_BITS - 1;
    localparam int MSB_BITS     = $clog2(MAG_BITS);
    // cordic module: magnitude, shift-count and pre-rotation stages, then iterations
    localparam int CORDIC_LAT   = 3 + CORDIC_ITERS;

    localparam logic [ANGLE_BITS-1:0] QUARTER_POS = 32'h4000_0000;
    localparam logic [ANGLE_BITS-1:0] QUARTER_NEG = 32'hC000_0000;

    localparam logic signed [TRIG_BITS-1:0] COS_Q14 [ROWS][MAX_STEPS] = '{
        '{16'sd16384, -16'sd8192,  -16'sd8192,  16'sd0,      16'sd0,
          16'sd0,     16'sd0,      16'sd0},
        '{16'sd16384, 16'sd0,      -16'sd16384, 16'sd0,      16'sd0,
          16'sd0,     16'sd0,      16'sd0},
        '{16'sd16384, 16'sd5063,   -16'sd13255, -16'sd13255, 16'sd5063,
          16'sd0,     16'sd0,      16'sd0},
        '{16'sd16384, 16'sd8192,   -16'sd8192,  -16'sd16384, -16'sd8192,
          16'sd8192,  16'sd0,      16'sd0},
        '{16'sd16384, 16'sd10215,  -16'sd3646,  -16'sd14761, -16'sd14761,
          -16'sd3646, 16'sd10215,  16'sd0},
        '{16'sd16384, 16'sd11585,  16'sd0,      -16'sd11585, -16'sd16384,
          -16'sd11585, 16'sd0,     16'sd11585}
    };

    localparam logic signed [TRIG_BITS-1:0] SIN_Q14 [ROWS][MAX_STEPS] = '{
        '{16'sd0, 16'sd14189, -16'sd14189, 16'sd0,      16'sd0,
          16'sd0,      16'sd0,      16'sd0},
        '{16'sd0, 16'sd16384, 16'sd0,      -16'sd16384, 16'sd0,
          16'sd0,      16'sd0,      16'sd0},
        '{16'sd0, 16'sd15582, 16'sd9630,   -16'sd9630,  -16'sd15582,
          16'sd0,      16'sd0,      16'sd0},
        '{16'sd0, 16'sd14189, 16'sd14189,  16'sd0,      -16'sd14189,
          -16'sd14189, 16'sd0,      16'sd0},
        '{16'sd0, 16'sd12810, 16'sd15973,  16'sd7109,   -16'sd7109,
          -16'sd15973, -16'sd12810, 16'sd0},
        '{16'sd0, 16'sd11585, 16'sd16384,  16'sd11585,  16'sd0,
          -16'sd11585, -16'sd16384, -16'sd11585}
    };

    // atan(2^-i), full circle = 2^32
    localparam logic [ANGLE_BITS-1:0] ATAN_TAB [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

endpackage

>>> rtl/nsps_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) with normalization and pre-rotation.
`timescale 1ns / 1ps
module nsps_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [nsps_pkg::SUM_BITS-1:0] i_y,
    input  logic signed [nsps_pkg::SUM_BITS-1:0] i_x,
    output logic [nsps_pkg::ANGLE_BITS-1:0]      o_angle
);
    import nsps_pkg::*;

    logic signed [SUM_BITS-1:0]   r_x0, r_y0, r_x1, r_y1;
    logic [MAG_BITS-1:0]          r_mag;
    logic [SHIFT_BITS-1:0]        r_shift;
    logic [MAG_BITS-1:0]          n_ax, n_ay;
    logic [MSB_BITS-1:0]          n_msb;
    logic signed [CW-1:0]         n_xs, n_ys;

    logic signed [CW-1:0]         r_x [CORDIC_ITERS+1];
    logic signed [CW-1:0]         r_y [CORDIC_ITERS+1];
    logic [ANGLE_BITS-1:0]        r_z [CORDIC_ITERS+1];

    always_comb begin
        n_ax = i_x[SUM_BITS-1] ? MAG_BITS'(-i_x) : i_x[MAG_BITS-1:0];
        n_ay = i_y[SUM_BITS-1] ? MAG_BITS'(-i_y) : i_y[MAG_BITS-1:0];
    end

    // only the top set bit of |x| | |y| matters for the shift count
    always_comb begin
        n_msb = '0;
        for (int p = 0; p < MAG_BITS; p++) begin
            if (r_mag[p]) n_msb = MSB_BITS'(p);
        end
    end

    always_comb begin
        n_xs = CW'(r_x1) <<< r_shift;
        n_ys = CW'(r_y1) <<< r_shift;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0    <= i_x;
            r_y0    <= i_y;
            r_mag   <= n_ax | n_ay;
            r_x1    <= r_x0;
            r_y1    <= r_y0;
            r_shift <= SHIFT_BITS'(NORM_EXP) - SHIFT_BITS'(n_msb);
            if (n_xs < 0) begin
                if (n_ys >= 0) begin
                    r_x[0] <= n_ys;
                    r_y[0] <= -n_xs;
                    r_z[0] <= QUARTER_POS;
                end else begin
                    r_x[0] <= -n_ys;
                    r_y[0] <= n_xs;
                    r_z[0] <= QUARTER_NEG;
                end
            end else begin
                r_x[0] <= n_xs;
                r_y[0] <= n_ys;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar gi = 0; gi < CORDIC_ITERS; gi++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[gi] > 0) begin
                    r_x[gi+1] <= r_x[gi] + (r_y[gi] >>> gi);
                    r_y[gi+1] <= r_y[gi] - (r_x[gi] >>> gi);
                    r_z[gi+1] <= r_z[gi] + ATAN_TAB[gi];
                end else begin
                    r_x[gi+1] <= r_x[gi] - (r_y[gi] >>> gi);
                    r_y[gi+1] <= r_y[gi] + (r_x[gi] >>> gi);
                    r_z[gi+1] <= r_z[gi] - ATAN_TAB[gi];
                end
            end
        end
    end

    assign o_angle = r_z[CORDIC_ITERS];

endmodule

>>> rtl/nstep_phase_shift_wrapper_core.sv
// N-step phase-shifting wrapped phase and mean intensity, top level.
`timescale 1ns / 1ps
// Takes one pixel's set of up to eight phase-shifted samples per cycle and returns
// -atan2(S, C) (32768 = pi), the mean of the first N samples with 4 fraction bits, and a
// flag when S and C are both zero. Fully pipelined: one word in and one out per cycle while
// not stalled (products, sums, 33 CORDIC stages, output register); the mean's divide by N
// runs bit-serially in stages alongside the CORDIC. A stall on the output while o_out_valid
// is high freezes the whole pipeline and is reflected on o_in_stall in the same cycle.
// N is written through the cfg port (always ready) and is clamped to 3..8.
module nstep_phase_shift_wrapper_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [nsps_pkg::STEP_BITS-1:0]        i_cfg_steps_in_use,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [nsps_pkg::SAMPLE_BITS-1:0]      i_sample_0,
    input  logic [nsps_pkg::SAMPLE_BITS-1:0]      i_sample_1,
    input  logic [nsps_pkg::SAMPLE_BITS-1:0]      i_sample_2,
    input  logic [nsps_pkg::SAMPLE_BITS-1:0]      i_sample_3,
    input  logic [nsps_pkg::SAMPLE_BITS-1:0]      i_sample_4,
    input  logic [nsps_pkg::SAMPLE_BITS-1:0]      i_sample_5,
    input  logic [nsps_pkg::SAMPLE_BITS-1:0]      i_sample_6,
    input  logic [nsps_pkg::SAMPLE_BITS-1:0]      i_sample_7,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [nsps_pkg::PHASE_BITS-1:0] o_wrapped_phase,
    output logic [nsps_pkg::MEAN_BITS-1:0]        o_mean_intensity,
    output logic                                  o_phase_undefined
);
    import nsps_pkg::*;

    typedef struct packed {
        logic                 valid;
        logic                 undef;
        logic [STEP_BITS-1:0] steps;
        logic [NUM_BITS-1:0]  num;
        logic [REM_BITS-1:0]  rem;
    } t_side;

    logic                          en;
    logic [STEP_BITS-1:0]          r_steps;
    logic [STEP_BITS-1:0]          n_steps;
    logic [ROW_BITS-1:0]           n_row;
    logic [SAMPLE_BITS-1:0]        n_smp [MAX_STEPS];

    logic                          r_v1;
    logic [STEP_BITS-1:0]          r_steps1;
    logic signed [PROD_BITS-1:0]   r_ps [MAX_STEPS];
    logic signed [PROD_BITS-1:0]   r_pc [MAX_STEPS];
    logic [SAMPLE_BITS-1:0]        r_smp [MAX_STEPS];

    logic signed [SUM_BITS-1:0]    n_s, n_c, r_s, r_c;
    logic [TOT_BITS-1:0]           n_tot;
    t_side                         r_side [CORDIC_LAT+1];
    logic [ANGLE_BITS-1:0]         cordic_z;
    logic [ANGLE_BITS-1:0]         n_rnd;

    logic                          r_out_valid;
    logic signed [PHASE_BITS-1:0]  r_phase;
    logic [MEAN_BITS-1:0]          r_mean;
    logic                          r_undef;

    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= STEP_BITS'(4);
        end else if (i_cfg_valid) begin
            r_steps <= i_cfg_steps_in_use;
        end
    end

    always_comb begin
        priority if (r_steps < STEP_BITS'(MIN_STEPS)) n_steps = STEP_BITS'(MIN_STEPS);
        else if (r_steps > STEP_BITS'(MAX_STEPS))     n_steps = STEP_BITS'(MAX_STEPS);
        else                                          n_steps = r_steps;
        n_row = ROW_BITS'(n_steps - STEP_BITS'(MIN_STEPS));
    end

    always_comb begin
        n_smp[0] = i_sample_0;
        n_smp[1] = i_sample_1;
        n_smp[2] = i_sample_2;
        n_smp[3] = i_sample_3;
        n_smp[4] = i_sample_4;
        n_smp[5] = i_sample_5;
        n_smp[6] = i_sample_6;
        n_smp[7] = i_sample_7;
    end

    // stage 1: mask unused steps, multiply by table row
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_steps1 <= n_steps;
            for (int k = 0; k < MAX_STEPS; k++) begin
                if (STEP_BITS'(k) < n_steps) begin
                    r_smp[k] <= n_smp[k];
                    r_ps[k]  <= PROD_BITS'($signed({1'b0, n_smp[k]}) * SIN_Q14[n_row][k]);
                    r_pc[k]  <= PROD_BITS'($signed({1'b0, n_smp[k]}) * COS_Q14[n_row][k]);
                end else begin
                    r_smp[k] <= '0;
                    r_ps[k]  <= '0;
                    r_pc[k]  <= '0;
                end
            end
        end
    end

    always_comb begin
        n_s   = '0;
        n_c   = '0;
        n_tot = '0;
        for (int k = 0; k < MAX_STEPS; k++) begin
            n_s   = n_s + SUM_BITS'(r_ps[k]);
            n_c   = n_c + SUM_BITS'(r_pc[k]);
            n_tot = n_tot + TOT_BITS'(r_smp[k]);
        end
    end

    // stage 2: sums, mean dividend
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1            <= 1'b0;
            r_side[0].valid <= 1'b0;
        end else if (en) begin
            r_v1            <= i_in_valid;
            r_side[0].valid <= r_v1;
        end
        if (en) begin
            r_s <= n_s;
            r_c <= n_c;
            r_side[0].undef <= (n_s == '0) && (n_c == '0);
            r_side[0].steps <= r_steps1;
            r_side[0].num   <= {n_tot, 4'b0000} + NUM_BITS'(r_steps1 >> 1);
            r_side[0].rem   <= '0;
        end
    end

    nsps_cordic u_cordic (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (r_s),
        .i_x     (r_c),
        .o_angle (cordic_z)
    );

    // sideband rides with the CORDIC; first NUM_BITS stages do restoring divide by N
    for (genvar gj = 0; gj < CORDIC_LAT; gj++) begin : g_side
        logic [REM_BITS:0] n_part;
        logic              n_ge;
        always_comb begin
            n_part = {r_side[gj].rem, r_side[gj].num[NUM_BITS-1]};
            n_ge   = n_part >= (REM_BITS+1)'(r_side[gj].steps);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[gj+1].valid <= 1'b0;
            end else if (en) begin
                r_side[gj+1].valid <= r_side[gj].valid;
            end
            if (en) begin
                r_side[gj+1].undef <= r_side[gj].undef;
                r_side[gj+1].steps <= r_side[gj].steps;
                if (gj < NUM_BITS) begin
                    r_side[gj+1].num <= {r_side[gj].num[NUM_BITS-2:0], n_ge};
                    r_side[gj+1].rem <= n_ge
                        ? REM_BITS'(n_part - (REM_BITS+1)'(r_side[gj].steps))
                        : REM_BITS'(n_part);
                end else begin
                    r_side[gj+1].num <= r_side[gj].num;
                    r_side[gj+1].rem <= r_side[gj].rem;
                end
            end
        end
    end

    // negate, round to PHASE_BITS; +pi wraps to -pi naturally
    assign n_rnd = (ANGLE_BITS'(0) - cordic_z) + (ANGLE_BITS'(1) << (ANGLE_BITS - 1 - PHASE_BITS));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_undef <= r_side[CORDIC_LAT].undef;
            r_phase <= r_side[CORDIC_LAT].undef ? '0 : $signed(n_rnd[ANGLE_BITS-1 -: PHASE_BITS]);
            r_mean  <= (r_side[CORDIC_LAT].num > NUM_BITS'({MEAN_BITS{1'b1}}))
                       ? {MEAN_BITS{1'b1}} : MEAN_BITS'(r_side[CORDIC_LAT].num);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_side[CORDIC_LAT].valid;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_wrapped_phase   = r_phase;
    assign o_mean_intensity  = r_mean;
    assign o_phase_undefined = r_undef;

endmodule

>>> tb/nstep_phase_shift_wrapper_core_tb.sv
// Self-checking testbench for the N-step phase-shift wrapped-phase core.
`timescale 1ns / 1ps
module nstep_phase_shift_wrapper_core_tb;
    import nsps_pkg::*;

    typedef struct packed {
        logic signed [PHASE_BITS-1:0] phase;
        logic [MEAN_BITS-1:0]         mean;
        logic                         undef_flag;
    } t_pixel_result;

    typedef logic [SAMPLE_BITS-1:0] t_sample_set [MAX_STEPS];

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [STEP_BITS-1:0] i_cfg_steps_in_use = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [SAMPLE_BITS-1:0] smp [MAX_STEPS];
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [PHASE_BITS-1:0] o_wrapped_phase;
    logic [MEAN_BITS-1:0] o_mean_intensity;
    logic o_phase_undefined;

    t_pixel_result pending_pixels[$];
    logic [STEP_BITS-1:0] steps_reg = 4'd4;
    int errors = 0;
    bit calm = 1'b0;
    bit stall_on = 1'b1;

    initial for (int k = 0; k < MAX_STEPS; k++) smp[k] = '0;

    always #6 i_clk = ~i_clk;

    nstep_phase_shift_wrapper_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_steps_in_use(i_cfg_steps_in_use),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_sample_0(smp[0]), .i_sample_1(smp[1]), .i_sample_2(smp[2]),
        .i_sample_3(smp[3]), .i_sample_4(smp[4]), .i_sample_5(smp[5]),
        .i_sample_6(smp[6]), .i_sample_7(smp[7]),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_wrapped_phase(o_wrapped_phase), .o_mean_intensity(o_mean_intensity),
        .o_phase_undefined(o_phase_undefined)
    );

    function automatic logic [31:0] cordic_angle(input longint y_in, input longint x_in);
        longint x, y, t, dx, dy;
        logic [31:0] z;
        x = x_in;
        y = y_in;
        z = '0;
        while ((x < 0 ? -x : x) < (64'sd1 <<< NORM_EXP) &&
               (y < 0 ? -y : y) < (64'sd1 <<< NORM_EXP)) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = QUARTER_POS;
            end else begin
                x = -y; y = t; z = QUARTER_NEG;
            end
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic t_pixel_result predict_pixel(input t_sample_set s_in,
                                                    input logic [STEP_BITS-1:0] steps);
        int n, row;
        longint s, c;
        longint unsigned total, m;
        logic [31:0] r;
        t_pixel_result res;
        n = steps < MIN_STEPS ? MIN_STEPS : (steps > MAX_STEPS ? MAX_STEPS : steps);
        row = n - MIN_STEPS;
        s = 0; c = 0; total = 0;
        for (int k = 0; k < n; k++) begin
            total += s_in[k];
            s += longint'(s_in[k]) * SIN_Q14[row][k];
            c += longint'(s_in[k]) * COS_Q14[row][k];
        end
        res = '0;
        if (s == 0 && c == 0) res.undef_flag = 1'b1;
        else begin
            r = (32'd0 - cordic_angle(s, c)) + (32'd1 << (31 - PHASE_BITS));
            res.phase = r[31 -: PHASE_BITS];
        end
        m = (total * 16 + n / 2) / n;
        res.mean = m > 64'hFFFF ? 16'hFFFF : m[15:0];
        return res;
    endfunction

    // idle burst on the sender side; valid drops only for the burst
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    // leaves valid high on return so the next word can follow without a gap
    task automatic send_pixel(input t_sample_set s_in);
        sender_gap();
        for (int k = 0; k < MAX_STEPS; k++) smp[k] <= s_in[k];
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_pixels.push_back(predict_pixel(s_in, steps_reg));
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (45) @(negedge i_clk);
    endtask

    task automatic write_steps(input logic [STEP_BITS-1:0] v);
        drain_pipeline();
        i_cfg_steps_in_use <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        steps_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_uniform(input int v);
        t_sample_set s;
        for (int k = 0; k < MAX_STEPS; k++) s[k] = SAMPLE_BITS'(v);
        send_pixel(s);
    endtask

    task automatic send_random(input int mode);
        t_sample_set s;
        for (int k = 0; k < MAX_STEPS; k++)
            case (mode)
                0: s[k] = SAMPLE_BITS'($urandom);
                1: s[k] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                default: s[k] = SAMPLE_BITS'(2000 + $urandom_range(0, 4));
            endcase
        send_pixel(s);
    endtask

    task automatic test_extremes();
        t_sample_set s;
        write_steps(4'd4);
        send_uniform(0);
        send_uniform(4095);
        send_uniform(1234);
        for (int n = 3; n <= 8; n++) begin
            write_steps(n[3:0]);
            for (int k = 0; k < MAX_STEPS; k++) s[k] = (k == 0) ? 12'd0 : 12'd4095;
            send_pixel(s);
            // S zero and C negative: phase sits at -pi
            for (int k = 0; k < MAX_STEPS; k++) s[k] = (k == 0) ? 12'd0 : 12'd100;
            send_pixel(s);
            for (int k = 0; k < MAX_STEPS; k++) s[k] = (k == 1) ? 12'd4095 : 12'd0;
            send_pixel(s);
        end
    endtask

    task automatic test_clamped_steps();
        write_steps(4'd0);
        send_random(0);
        write_steps(4'd2);
        send_random(0);
        write_steps(4'd15);
        send_random(0);
        write_steps(4'd9);
        send_random(1);
    endtask

    task automatic test_random_sets();
        for (int p = 0; p < 8; p++) begin
            write_steps(STEP_BITS'($urandom_range(0, 15)));
            if (p == 7) calm = 1'b1;
            for (int i = 0; i < 155; i++) send_random($urandom_range(0, 5) < 4 ? 0 :
                                                     $urandom_range(1, 2));
        end
    endtask

    always @(negedge i_clk) begin
        if (calm) i_out_stall <= 1'b0;
        else if (!stall_on) begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 7) == 0) stall_on <= 1'b1;
        end else begin
            i_out_stall <= 1'($urandom_range(0, 1));
            if ($urandom_range(0, 5) == 0) stall_on <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_pixel_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected word: phase %0d mean %0d", o_wrapped_phase,
                       o_mean_intensity);
                errors++;
            end else begin
                exp_r = pending_pixels.pop_front();
                if (o_wrapped_phase !== exp_r.phase) begin
                    $error("wrapped_phase exp %0d got %0d", exp_r.phase, o_wrapped_phase);
                    errors++;
                end
                if (o_mean_intensity !== exp_r.mean) begin
                    $error("mean_intensity exp %0d got %0d", exp_r.mean, o_mean_intensity);
                    errors++;
                end
                if (o_phase_undefined !== exp_r.undef_flag) begin
                    $error("phase_undefined exp %0d got %0d", exp_r.undef_flag,
                           o_phase_undefined);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_clamped_steps();
        test_random_sets();
        drain_pipeline();
        if (errors == 0 && pending_pixels.size() == 0)
            $display("nstep_phase_shift_wrapper_core_tb: PASS");
        else
            $display("nstep_phase_shift_wrapper_core_tb: FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("nstep_phase_shift_wrapper_core_tb: FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/nsps_pkg.sv
rtl/nsps_cordic.sv
rtl/nstep_phase_shift_wrapper_core.sv
tb/nstep_phase_shift_wrapper_core_tb.sv
